// ===== rtl/bst_pkg.sv =====
// Package for the bidirectional session table: sizes, codes, FSM states and hash.
// No dependencies.
package bst_pkg;
    localparam int BUCKET_BITS = 12;
    localparam int WAYS        = 4;
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_BITS   = $clog2(WAYS + 1);
    localparam int SLOT_BITS   = BUCKET_BITS + WAY_BITS;
    localparam int NBUCKETS    = 1 << BUCKET_BITS;
    localparam int NSLOTS      = 1 << SLOT_BITS;
    // entry: server ip, client ip, server port, client port, smac, cmac, proto, created
    localparam int ENT_W       = 32 + 32 + 16 + 16 + 48 + 48 + 8 + 32;
    // request: kind, four-tuple, MACs, server endpoint, proto, now
    localparam int IN_W        = 2 + 32 + 32 + 16 + 16 + 48 + 48 + 32 + 16 + 8 + 32;
    localparam int IN_TD_W     = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 3 + ENT_W + 32;
    localparam int OUT_TD_W    = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        K_FIND   = 2'd0,
        K_CREATE = 2'd1,
        K_REMOVE = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_CREATED   = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_MISSED    = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDFILL,
        S_READ,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_OUT
    } t_state;

    function automatic logic [BUCKET_BITS-1:0] bucket_of(
        input logic [31:0] a, input logic [31:0] b,
        input logic [15:0] pa, input logic [15:0] pb);
        logic [31:0] h;
        h = a ^ b ^ {16'd0, pa} ^ {16'd0, pb};
        h = h ^ (h >> 16);
        h = h ^ (h >> 8);
        return h[BUCKET_BITS-1:0];
    endfunction
endpackage

// ===== rtl/bidirectional_session_table.sv =====
// Top level of the bidirectional session table: sequencer, compare unit, stores.
// Depends on bst_pkg and bst_ram.
//
// Usage: a request beat on s_axis (kind, four-tuple, MACs, server endpoint,
// protocol, now) yields exactly one result beat on m_axis (status, session).
// Requests go one at a time; s_axis_tready is high only when idle with no
// result waiting. Entries live in one RAM of WAYS slots per bucket, refresh
// stamps in a second RAM, per-bucket fill counts in a third. The sequencer
// reads the fill count, then walks the bucket one way at a time through one
// shared four-tuple comparator (read, then compare, for each way). Create and
// unknown kinds skip the walk; a remove hit shifts the later entries of the
// bucket down one slot. The next request is taken only after the result beat
// is accepted. After reset a clearing pass over all NBUCKETS buckets zeroes
// the fill RAM, with s_axis_tready low. While m_axis_tready is low the result
// waits in its register and no new request is taken.
module bidirectional_session_table
    import bst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // kind, src_ip, dst_ip, src_port, dst_port, src_mac, dst_mac,
    // server_ip, server_port, protocol_id, now, zero pad
    input  logic [IN_TD_W-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // status, sess_server_ip, sess_client_ip, sess_server_port,
    // sess_client_port, sess_server_mac, sess_client_mac, sess_protocol,
    // sess_created, sess_refreshed, zero pad
    output logic [OUT_TD_W-1:0] m_axis_tdata
);
    t_state r_state, n_state;

    logic [1:0]  r_kind;
    logic [31:0] r_sip, r_dip, r_srv_ip, r_now;
    logic [15:0] r_spt, r_dpt, r_srv_pt;
    logic [47:0] r_smac, r_dmac;
    logic [7:0]  r_proto;
    logic [BUCKET_BITS-1:0] r_bkt;
    logic [FILL_BITS-1:0]   r_fill;
    logic [FILL_BITS-1:0]   r_way;
    logic [BUCKET_BITS:0]   r_clr;
    logic [2:0]             r_status;
    logic [ENT_W-1:0]       r_oent;
    logic [31:0]            r_oref;
    logic                   r_ovalid;

    // ram ports
    logic                   ent_we, ref_we, fill_we;
    logic [SLOT_BITS-1:0]   ent_waddr, ent_raddr;
    logic [ENT_W-1:0]       ent_wdata, ent_rdata;
    logic [31:0]            ref_wdata, ref_rdata;
    logic [BUCKET_BITS-1:0] fill_waddr, fill_raddr;
    logic [FILL_BITS-1:0]   fill_wdata, fill_rdata;

    logic [WAY_BITS-1:0] way_ix, way_nx;
    assign way_ix = r_way[WAY_BITS-1:0];
    assign way_nx = WAY_BITS'(r_way + FILL_BITS'(1));

    bst_ram #(.WIDTH(ENT_W), .DEPTH(NSLOTS)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata));
    bst_ram #(.WIDTH(32), .DEPTH(NSLOTS)) u_ref (
        .i_clk(i_clk), .i_we(ref_we), .i_waddr(ent_waddr), .i_wdata(ref_wdata),
        .i_raddr(ent_raddr), .o_rdata(ref_rdata));
    bst_ram #(.WIDTH(FILL_BITS), .DEPTH(NBUCKETS)) u_fill (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(fill_waddr), .i_wdata(fill_wdata),
        .i_raddr(fill_raddr), .o_rdata(fill_rdata));

    logic clearing;
    assign clearing = !r_clr[BUCKET_BITS];

    logic [31:0] e_sip, e_cip;
    logic [15:0] e_spt, e_cpt;
    assign e_sip = ent_rdata[ENT_W-1 -: 32];
    assign e_cip = ent_rdata[ENT_W-33 -: 32];
    assign e_spt = ent_rdata[ENT_W-65 -: 16];
    assign e_cpt = ent_rdata[ENT_W-81 -: 16];

    // shared four-tuple comparator
    logic hit;
    assign hit = (e_sip == r_sip && e_cip == r_dip && e_spt == r_spt && e_cpt == r_dpt) ||
                 (e_sip == r_dip && e_cip == r_sip && e_spt == r_dpt && e_cpt == r_spt);

    logic src_srv;
    assign src_srv = (r_srv_ip == r_sip) && (r_srv_pt == r_spt);
    logic [ENT_W-1:0] new_ent;
    assign new_ent = src_srv ?
        {r_sip, r_dip, r_spt, r_dpt, r_smac, r_dmac, r_proto, r_now} :
        {r_dip, r_sip, r_dpt, r_spt, r_dmac, r_smac, r_proto, r_now};

    logic in_acc, out_acc, full;
    assign s_axis_tready = (r_state == S_IDLE) && !clearing && !r_ovalid;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = r_ovalid && m_axis_tready;
    assign full    = r_fill >= FILL_BITS'(WAYS);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_RDFILL;
            S_RDFILL: n_state = S_READ;
            S_READ: begin
                if (t_kind'(r_kind) == K_CREATE || t_kind'(r_kind) == K_NONE ||
                    r_way >= r_fill) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (hit && t_kind'(r_kind) == K_REMOVE) begin
                    n_state = (r_way + FILL_BITS'(1) < r_fill) ? S_SHRD : S_OUT;
                end else if (hit) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_SHRD:   n_state = S_SHWR;
            // r_way still names the slot being written this cycle
            S_SHWR:   n_state = (r_way + FILL_BITS'(2) < r_fill) ? S_SHRD : S_OUT;
            S_OUT:    if (!r_ovalid || out_acc) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ram controls
    always_comb begin
        ent_we     = 1'b0;
        ref_we     = 1'b0;
        fill_we    = 1'b0;
        ent_raddr  = {r_bkt, way_ix};
        ent_waddr  = {r_bkt, way_ix};
        ent_wdata  = new_ent;
        ref_wdata  = r_now;
        fill_raddr = bucket_of(s_axis_tdata[33:2], s_axis_tdata[65:34],
                               s_axis_tdata[81:66], s_axis_tdata[97:82]);
        fill_waddr = r_bkt;
        fill_wdata = r_fill;
        if (clearing) begin
            fill_we    = 1'b1;
            fill_waddr = r_clr[BUCKET_BITS-1:0];
            fill_wdata = '0;
        end else begin
            case (r_state)
                S_READ: begin
                    if (t_kind'(r_kind) == K_CREATE && !full) begin
                        ent_we     = 1'b1;
                        ref_we     = 1'b1;
                        ent_waddr  = {r_bkt, r_fill[WAY_BITS-1:0]};
                        fill_we    = 1'b1;
                        fill_wdata = r_fill + FILL_BITS'(1);
                    end
                end
                S_CMP: begin
                    if (hit && t_kind'(r_kind) == K_FIND) begin
                        ref_we = 1'b1;
                    end
                    if (hit && t_kind'(r_kind) == K_REMOVE) begin
                        fill_we    = 1'b1;
                        fill_wdata = r_fill - FILL_BITS'(1);
                    end
                end
                S_SHRD: ent_raddr = {r_bkt, way_nx};
                S_SHWR: begin
                    ent_we    = 1'b1;
                    ref_we    = 1'b1;
                    ent_wdata = ent_rdata;
                    ref_wdata = ref_rdata;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + (BUCKET_BITS+1)'(1);
            if (out_acc) begin
                r_ovalid <= 1'b0;
            end else if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind   <= s_axis_tdata[1:0];
                r_sip    <= s_axis_tdata[33:2];
                r_dip    <= s_axis_tdata[65:34];
                r_spt    <= s_axis_tdata[81:66];
                r_dpt    <= s_axis_tdata[97:82];
                r_smac   <= s_axis_tdata[145:98];
                r_dmac   <= s_axis_tdata[193:146];
                r_srv_ip <= s_axis_tdata[225:194];
                r_srv_pt <= s_axis_tdata[241:226];
                r_proto  <= s_axis_tdata[249:242];
                r_now    <= s_axis_tdata[281:250];
                r_bkt    <= fill_raddr;
                r_way    <= '0;
            end
            S_RDFILL: begin
                r_fill   <= fill_rdata;
                r_oent   <= '0;
                r_oref   <= '0;
                case (t_kind'(r_kind))
                    K_FIND:   r_status <= ST_NOT_FOUND;
                    K_REMOVE: r_status <= ST_MISSED;
                    K_CREATE: r_status <= ST_CREATED;
                    default:  r_status <= ST_NOT_FOUND;
                endcase
            end
            S_READ: begin
                if (t_kind'(r_kind) == K_CREATE) begin
                    if (full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_oent <= new_ent;
                        r_oref <= r_now;
                    end
                end
            end
            S_CMP: begin
                if (hit) begin
                    if (t_kind'(r_kind) == K_FIND) begin
                        r_status <= ST_FOUND;
                        r_oent   <= ent_rdata;
                        r_oref   <= r_now;
                    end else begin
                        r_status <= ST_REMOVED;
                    end
                end else begin
                    r_way <= r_way + FILL_BITS'(1);
                end
            end
            S_SHWR: r_way <= r_way + FILL_BITS'(1);
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_TD_W'({r_oref, r_oent[31:0], r_oent[39:32],
                            r_oent[87:40], r_oent[135:88], r_oent[151:136],
                            r_oent[167:152], r_oent[199:168], r_oent[231:200],
                            r_status});
endmodule

// ===== rtl/bst_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
